>>> design/wsnt_pkg.sv
// Shared types, codes and sizes of the weight-sorted neighbor table.
package wsnt_pkg;

  localparam int MAX_CONN = 32;
  localparam int ID_WIDTH = 16;
  localparam int MAX_RUN  = 32;
  localparam int IDX_W    = $clog2(MAX_CONN);
  localparam int CNT_W    = $clog2(MAX_CONN + 1);
  localparam int WGT_W    = 16;

  localparam logic [2:0] FN_SET   = 3'd0;
  localparam logic [2:0] FN_ERASE = 3'd1;
  localparam logic [2:0] FN_GET   = 3'd2;
  localparam logic [2:0] FN_BEST  = 3'd3;
  localparam logic [2:0] FN_ATL   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNCH  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [WGT_W-1:0]    weight;
    logic [ID_WIDTH-1:0] id;
  } entry_t;

  typedef struct packed {
    logic id_eq;     // stored id equals the key id
    logic ahead;     // key sorts ahead of the stored entry
    logic at_least;  // stored weight >= key weight
  } cmp_res_t;

endpackage

>>> design/wsnt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wsnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/wsnt_cmp.sv
// Shared compare unit: key entry against one stored entry.
module wsnt_cmp (
  input  wsnt_pkg::entry_t   key,
  input  wsnt_pkg::entry_t   stored,
  output wsnt_pkg::cmp_res_t res
);

  always_comb begin
    res.id_eq    = (key.id == stored.id);
    // higher weight first, ties to the higher id
    res.ahead    = ({key.weight, key.id} > {stored.weight, stored.id});
    res.at_least = (stored.weight >= key.weight);
  end

endmodule

>>> design/weight_sorted_neighbor_table_unit.sv
// Weight-sorted neighbor table: top level with sequencer, entry RAM and compare unit.
//
// Keeps up to MAX_CONN (id, weight) entries in a RAM, sorted by weight then id,
// highest first. Every operation runs under one sequencer that walks the RAM with
// a single compare unit; the RAM's registered read means each entry visited takes
// a read state and then a check or write state. Set, erase and get first scan for
// the id, entry by entry up to the match or the end of the table; an update or erase
// then closes the gap behind it and a set walks the insertion point up from the tail.
// Best n emits its results one by one, each held back while the output register is
// full; at least weight first scans the qualifying prefix and then emits likewise.
// in_tready is high only while the sequencer is idle; a finished result waits in
// the output register.
module weight_sorted_neighbor_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // peer_id[15:0], weight_value[31:16], count_n[37:32]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_id[15:0], out_weight[31:16]
  output logic [2:0]  out_tuser,  // entry_valid[0], status[2:1]
  output logic        out_tlast
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_DEL_RD   = 4'd4;
  localparam logic [3:0] S_DEL_WR   = 4'd5;
  localparam logic [3:0] S_INS_RD   = 4'd6;
  localparam logic [3:0] S_INS_CHK  = 4'd7;
  localparam logic [3:0] S_LIST_RD  = 4'd8;
  localparam logic [3:0] S_LIST_OUT = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  localparam int LW = 8;

  logic [3:0]                   state_r, state_nxt;
  logic [wsnt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [wsnt_pkg::CNT_W-1:0]   i_r, i_nxt;
  logic [wsnt_pkg::CNT_W-1:0]   lim_r, lim_nxt;
  logic [wsnt_pkg::CNT_W-1:0]   pos_r, pos_nxt;
  logic                         found_r, found_nxt;
  logic [wsnt_pkg::WGT_W-1:0]   fw_r, fw_nxt;
  logic [2:0]                   func_r, func_nxt;
  wsnt_pkg::entry_t             key_r, key_nxt;
  logic [5:0]                   n_r, n_nxt;

  // pending single result
  wsnt_pkg::entry_t             res_r, res_nxt;
  logic                         res_vld_r, res_vld_nxt;
  logic [1:0]                   res_st_r, res_st_nxt;

  logic                         out_valid_r, out_valid_nxt;
  wsnt_pkg::entry_t             out_ent_r, out_ent_nxt;
  logic                         out_ev_r, out_ev_nxt;
  logic [1:0]                   out_st_r, out_st_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         ram_we, ram_re;
  logic [wsnt_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
  wsnt_pkg::entry_t             ram_wdata, ram_rdata;
  wsnt_pkg::cmp_res_t           cmp;

  logic                         in_acc, out_free, out_load;
  logic [LW-1:0]                lim_w;

  wsnt_ram #(
    .WIDTH($bits(wsnt_pkg::entry_t)),
    .DEPTH(wsnt_pkg::MAX_CONN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wsnt_cmp u_cmp (
    .key    (key_r),
    .stored (ram_rdata),
    .res    (cmp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    lim_nxt      = lim_r;
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    fw_nxt       = fw_r;
    func_nxt     = func_r;
    key_nxt      = key_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    res_vld_nxt  = res_vld_r;
    res_st_nxt   = res_st_r;
    out_ent_nxt  = out_ent_r;
    out_ev_nxt   = out_ev_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = i_r[wsnt_pkg::IDX_W-1:0];
    ram_raddr    = i_r[wsnt_pkg::IDX_W-1:0];
    ram_wdata    = key_r;
    lim_w        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt       = in_tuser;
          key_nxt.id     = wsnt_pkg::ID_WIDTH'(in_tdata[15:0]);
          key_nxt.weight = in_tdata[31:16];
          n_nxt          = in_tdata[37:32];
          i_nxt          = '0;
          found_nxt      = 1'b0;
          if (in_tuser == wsnt_pkg::FN_SET || in_tuser == wsnt_pkg::FN_ERASE ||
              in_tuser == wsnt_pkg::FN_GET || in_tuser == wsnt_pkg::FN_ATL) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_SCAN_RD: begin
        if (i_r == cnt_r) begin
          state_nxt = S_DECIDE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (func_r == wsnt_pkg::FN_ATL) begin
          // i counts the qualifying prefix
          if (cmp.at_least) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_DECIDE;
          end
        end else if (cmp.id_eq) begin
          found_nxt = 1'b1;
          pos_nxt   = i_r;
          fw_nxt    = ram_rdata.weight;
          state_nxt = S_DECIDE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        res_nxt     = key_r;
        res_vld_nxt = 1'b1;
        res_st_nxt  = wsnt_pkg::ST_OK;
        state_nxt   = S_DONE;
        unique case (func_r)
          wsnt_pkg::FN_SET: begin
            if (found_r && fw_r == key_r.weight) begin
              res_st_nxt = wsnt_pkg::ST_UNCH;
            end else if (found_r) begin
              i_nxt     = pos_r;
              state_nxt = S_DEL_RD;
            end else if (cnt_r == wsnt_pkg::CNT_W'(wsnt_pkg::MAX_CONN)) begin
              res_nxt     = '0;
              res_vld_nxt = 1'b0;
              res_st_nxt  = wsnt_pkg::ST_FULL;
            end else begin
              i_nxt     = cnt_r;
              state_nxt = S_INS_RD;
            end
          end
          wsnt_pkg::FN_ERASE, wsnt_pkg::FN_GET: begin
            if (found_r) begin
              res_nxt.weight = fw_r;
              if (func_r == wsnt_pkg::FN_ERASE) begin
                i_nxt     = pos_r;
                state_nxt = S_DEL_RD;
              end
            end else begin
              res_nxt     = '0;
              res_vld_nxt = 1'b0;
              res_st_nxt  = wsnt_pkg::ST_UNCH;
            end
          end
          wsnt_pkg::FN_BEST, wsnt_pkg::FN_ATL: begin
            if (func_r == wsnt_pkg::FN_BEST) begin
              lim_w = (LW'(n_r) < LW'(cnt_r)) ? LW'(n_r) : LW'(cnt_r);
            end else begin
              lim_w = LW'(i_r);
            end
            if (lim_w > LW'(wsnt_pkg::MAX_RUN)) begin
              lim_w = LW'(wsnt_pkg::MAX_RUN);
            end
            lim_nxt = wsnt_pkg::CNT_W'(lim_w);
            i_nxt   = '0;
            if (lim_w == '0) begin
              res_nxt     = '0;
              res_vld_nxt = 1'b0;
              res_st_nxt  = wsnt_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_LIST_RD;
            end
          end
          default: begin
            res_nxt     = '0;
            res_vld_nxt = 1'b0;
            res_st_nxt  = wsnt_pkg::ST_UNCH;
          end
        endcase
      end
      S_DEL_RD: begin
        // close the gap: entry i+1 moves down to i
        if ((i_r + 1'b1) >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          if (func_r == wsnt_pkg::FN_SET) begin
            i_nxt     = cnt_r - 1'b1;
            state_nxt = S_INS_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wsnt_pkg::IDX_W'(i_r + 1'b1);
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_INS_RD: begin
        if (i_r == '0) begin
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wsnt_pkg::IDX_W'(i_r - 1'b1);
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        ram_we = 1'b1;
        if (cmp.ahead) begin
          ram_wdata = ram_rdata;
          i_nxt     = i_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_LIST_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_ent_nxt  = ram_rdata;
          out_ev_nxt   = 1'b1;
          out_st_nxt   = wsnt_pkg::ST_OK;
          out_last_nxt = ((i_r + 1'b1) == lim_r);
          i_nxt        = i_r + 1'b1;
          state_nxt    = ((i_r + 1'b1) == lim_r) ? S_IDLE : S_LIST_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_ent_nxt  = res_r;
          out_ev_nxt   = res_vld_r;
          out_st_nxt   = res_st_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    lim_r      <= lim_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    fw_r       <= fw_nxt;
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    res_vld_r  <= res_vld_nxt;
    res_st_r   <= res_st_nxt;
    out_ent_r  <= out_ent_nxt;
    out_ev_r   <= out_ev_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ent_r.weight, 16'(out_ent_r.id)};
  assign out_tuser  = {out_st_r, out_ev_r};
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wsnt_pkg::CNT_W'(wsnt_pkg::MAX_CONN))
    else $error("entry count above table size");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DEL_WR || state_r == S_INS_RD || state_r == S_INS_CHK))
    else $error("RAM write outside shift or insert");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item left no work");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending transfer");

  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_nxt == S_IDLE) |-> (out_load && out_last_nxt))
    else $error("operation ended without its last result");

endmodule
